### src/line_pixel_generator_core_assert.svh
// Assertion macros for the line pixel generator step module.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef LINE_PIXEL_GENERATOR_CORE_ASSERT_SVH
`define LINE_PIXEL_GENERATOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/lpg_pkg.sv
package lpg_pkg;

  localparam int unsigned ColorBits = 16;
  // Extra decision bits over the coordinate width: sign plus doubled deltas.
  localparam int unsigned DecExtraBits = 3;

  localparam logic KindAdvance = 1'b0;
  localparam logic KindStart   = 1'b1;

  // Control flags held with a registered input word.
  typedef struct packed {
    logic valid;
    logic kind;
    logic x_major;
    logic x_negative;
    logic y_negative;
  } lpg_ctrl_t;

endpackage

### src/lpg_in_if.sv
interface lpg_in_if
  import lpg_pkg::*;
#(
  parameter int unsigned COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  logic [ColorBits-1:0]  line_color;

  modport source (
    output valid, kind, start_x, start_y, end_x, end_y, line_color,
    input  ready
  );

  modport sink (
    input  valid, kind, start_x, start_y, end_x, end_y, line_color,
    output ready
  );
endinterface

### src/lpg_out_if.sv
interface lpg_out_if
  import lpg_pkg::*;
#(
  parameter int unsigned COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [ColorBits-1:0]  pixel_color;
  logic                  last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last,
    output ready
  );
endinterface

### src/lpg_setup.sv
module lpg_setup
  import lpg_pkg::*;
#(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  lpg_in_if.sink                               line_i,
  input  logic                                 take_i,
  output lpg_ctrl_t                            ctrl_o,
  output logic [COORD_BITS-1:0]                start_x_o,
  output logic [COORD_BITS-1:0]                start_y_o,
  output logic [COORD_BITS-1:0]                major_o,
  output logic [COORD_BITS-1:0]                minor_o,
  output logic signed [COORD_BITS+DecExtraBits-1:0] decision_o,
  output logic [ColorBits-1:0]                 color_o
);

  localparam int unsigned DecBits = COORD_BITS + DecExtraBits;

  logic                  valid_q;
  logic                  x_neg, y_neg, x_maj;
  logic [COORD_BITS-1:0] adx, ady, major, minor;
  logic signed [DecBits-1:0] dec_init;
  lpg_ctrl_t             ctrl_q;
  logic [COORD_BITS-1:0] sx_q, sy_q, major_q, minor_q;
  logic signed [DecBits-1:0] dec_q;
  logic [ColorBits-1:0]  color_q;

  // Deltas, directions and the first decision term of a new line.
  always_comb begin
    x_neg    = line_i.end_x < line_i.start_x;
    y_neg    = line_i.end_y < line_i.start_y;
    adx      = x_neg ? (line_i.start_x - line_i.end_x) : (line_i.end_x - line_i.start_x);
    ady      = y_neg ? (line_i.start_y - line_i.end_y) : (line_i.end_y - line_i.start_y);
    x_maj    = adx > ady;
    major    = x_maj ? adx : ady;
    minor    = x_maj ? ady : adx;
    dec_init = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
  end

  // Accept when empty or when the step stage drains this word.
  assign line_i.ready = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (line_i.ready) begin
      valid_q <= line_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_i.valid && line_i.ready) begin
      ctrl_q.valid      <= 1'b1;
      ctrl_q.kind       <= line_i.kind;
      ctrl_q.x_major    <= x_maj;
      ctrl_q.x_negative <= x_neg;
      ctrl_q.y_negative <= y_neg;
      sx_q              <= line_i.start_x;
      sy_q              <= line_i.start_y;
      major_q           <= major;
      minor_q           <= minor;
      dec_q             <= dec_init;
      color_q           <= line_i.line_color;
    end
  end

  always_comb begin
    ctrl_o.valid      = valid_q;
    ctrl_o.kind       = ctrl_q.kind;
    ctrl_o.x_major    = ctrl_q.x_major;
    ctrl_o.x_negative = ctrl_q.x_negative;
    ctrl_o.y_negative = ctrl_q.y_negative;
  end

  assign start_x_o  = sx_q;
  assign start_y_o  = sy_q;
  assign major_o    = major_q;
  assign minor_o    = minor_q;
  assign decision_o = dec_q;
  assign color_o    = color_q;

endmodule

### src/lpg_step.sv
`include "line_pixel_generator_core_assert.svh"

module lpg_step
  import lpg_pkg::*;
#(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lpg_ctrl_t                            ctrl_i,
  input  logic [COORD_BITS-1:0]                start_x_i,
  input  logic [COORD_BITS-1:0]                start_y_i,
  input  logic [COORD_BITS-1:0]                major_i,
  input  logic [COORD_BITS-1:0]                minor_i,
  input  logic signed [COORD_BITS+DecExtraBits-1:0] decision_i,
  input  logic [ColorBits-1:0]                 color_i,
  output logic                                 take_o,
  lpg_out_if.source                            pixel_o
);

  localparam int unsigned DecBits = COORD_BITS + DecExtraBits;
  localparam logic [COORD_BITS-1:0] CoordOne = COORD_BITS'(1);

  // Line state.
  logic                      active_q, active_d;
  logic [COORD_BITS-1:0]     cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [DecBits-1:0] dec_q, dec_d;
  logic [COORD_BITS-1:0]     rem_q, rem_d;
  logic [COORD_BITS-1:0]     maj_q, min_q;
  logic                      xm_q, xn_q, yn_q;
  logic [ColorBits-1:0]      color_q;

  // Output register.
  logic                      out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0]     px_q, py_q;
  logic [ColorBits-1:0]      pc_q;
  logic                      last_q;

  // Working values for the word being stepped.
  logic [COORD_BITS-1:0]     b_x, b_y, b_rem, b_maj, b_min;
  logic signed [DecBits-1:0] b_dec, tmaj, tmin;
  logic                      b_xm, b_xn, b_yn;
  logic [ColorBits-1:0]      b_color;
  logic                      rem_zero, dec_ge, step_x, step_y;
  logic                      out_free, load;

  assign out_free = !out_valid_q || pixel_o.ready;
  assign take_o   = ctrl_i.valid && out_free;
  // Advance while idle is taken and dropped.
  assign load     = take_o && (ctrl_i.kind == KindStart || active_q);

  always_comb begin
    if (ctrl_i.kind == KindStart) begin
      b_x     = start_x_i;
      b_y     = start_y_i;
      b_dec   = decision_i;
      b_rem   = major_i;
      b_maj   = major_i;
      b_min   = minor_i;
      b_xm    = ctrl_i.x_major;
      b_xn    = ctrl_i.x_negative;
      b_yn    = ctrl_i.y_negative;
      b_color = color_i;
    end else begin
      b_x     = cur_x_q;
      b_y     = cur_y_q;
      b_dec   = dec_q;
      b_rem   = rem_q;
      b_maj   = maj_q;
      b_min   = min_q;
      b_xm    = xm_q;
      b_xn    = xn_q;
      b_yn    = yn_q;
      b_color = color_q;
    end

    rem_zero = b_rem == '0;
    dec_ge   = !b_dec[DecBits-1];
    tmaj     = $signed({2'b00, b_maj, 1'b0});
    tmin     = $signed({2'b00, b_min, 1'b0});

    // Major axis always steps; minor axis steps when the error is non-negative.
    step_x   = b_xm ? 1'b1 : dec_ge;
    step_y   = b_xm ? dec_ge : 1'b1;

    active_d = !rem_zero;
    cur_x_d  = b_x;
    cur_y_d  = b_y;
    dec_d    = b_dec;
    rem_d    = b_rem;
    if (!rem_zero) begin
      if (step_x) begin
        cur_x_d = b_xn ? (b_x - CoordOne) : (b_x + CoordOne);
      end
      if (step_y) begin
        cur_y_d = b_yn ? (b_y - CoordOne) : (b_y + CoordOne);
      end
      dec_d = b_dec - (dec_ge ? tmaj : '0) + tmin;
      rem_d = b_rem - CoordOne;
    end

    if (load) begin
      out_valid_d = 1'b1;
    end else if (pixel_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (load) begin
        active_q <= active_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      dec_q   <= dec_d;
      rem_q   <= rem_d;
      maj_q   <= b_maj;
      min_q   <= b_min;
      xm_q    <= b_xm;
      xn_q    <= b_xn;
      yn_q    <= b_yn;
      color_q <= b_color;
      px_q    <= b_x;
      py_q    <= b_y;
      pc_q    <= b_color;
      last_q  <= rem_zero;
    end
  end

  assign pixel_o.valid       = out_valid_q;
  assign pixel_o.pixel_x     = px_q;
  assign pixel_o.pixel_y     = py_q;
  assign pixel_o.pixel_color = pc_q;
  assign pixel_o.last        = last_q;

  `LPG_ASSERT_NEXT(a_idle_advance_silent,
    take_o && ctrl_i.kind == KindAdvance && !active_q, !out_valid_q,
    "advance while idle produced a pixel")
  `LPG_ASSERT_NEXT(a_last_ends_line, load && rem_zero, !active_q && last_q,
    "final pixel did not end the line")
  `LPG_ASSERT_SAME(a_major_dominates, active_q, maj_q >= min_q,
    "minor delta exceeds major delta")

endmodule

### src/line_pixel_generator_core.sv
// Bresenham line pixel generator.
// Channel line_i takes words of two kinds. A start word carries two endpoints
// and an RGB565 color; it loads the line and yields its first pixel. An advance
// word yields the next pixel of the active line; with no line active it is
// consumed and yields nothing. A start while a line is active drops that line.
// Channel pixel_o returns one word per pixel: x, y, color and last, which
// marks the final pixel. A line of major length L gives L + 1 pixels.
// A word taken on line_i passes the input register, then the output register,
// before its pixel shows on pixel_o. Throughput: one word per cycle while
// pixel_o does not stall, set by the single step stage, whose work is one
// add-subtract and compare. Reset clears the valid flags and ends any line; the
// first word after reset is usually a start. When the pixel receiver stalls, the
// output register holds its word, the input register fills, and line_i.ready
// drops until the stall clears; nothing is lost or repeated.
module line_pixel_generator_core
  import lpg_pkg::*;
#(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpg_in_if.sink     line_i,
  lpg_out_if.source  pixel_o
);

  localparam int unsigned DecBits = COORD_BITS + DecExtraBits;

  lpg_ctrl_t                 ctrl;
  logic                      take;
  logic [COORD_BITS-1:0]     start_x, start_y, major, minor;
  logic signed [DecBits-1:0] decision;
  logic [ColorBits-1:0]      color;

  // Input register: hold the word with its precomputed line setup.
  lpg_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .line_i     (line_i),
    .take_i     (take),
    .ctrl_o     (ctrl),
    .start_x_o  (start_x),
    .start_y_o  (start_y),
    .major_o    (major),
    .minor_o    (minor),
    .decision_o (decision),
    .color_o    (color)
  );

  // Step stage: advance the line state and load the output register.
  lpg_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .start_x_i  (start_x),
    .start_y_i  (start_y),
    .major_i    (major),
    .minor_i    (minor),
    .decision_i (decision),
    .color_i    (color),
    .take_o     (take),
    .pixel_o    (pixel_o)
  );

endmodule
